// ----- hw/rtl/sorted_keyed_part_table_macros.svh -----
// Assertion macros for the sorted keyed part table checker.
// Expects clk and rst in the scope of use.
`ifndef SORTED_KEYED_PART_TABLE_MACROS_SVH
`define SORTED_KEYED_PART_TABLE_MACROS_SVH

// same-cycle implication
`define SKT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/skt_pkg.sv -----
// Shared types, widths and codes of the sorted keyed part table.
// No dependencies.
`default_nettype none
package skt_pkg;

  localparam int TYPE_W       = 3;
  localparam int KEY_W        = 31;
  localparam int QTY_W        = 32;
  localparam int STAT_W       = 3;
  localparam int DEF_CAPACITY = 32;

  localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_SEARCH = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_UPDATE = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_ERASE  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_DUMP   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NFOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEEK,
    S_SHUP,
    S_INS_WR,
    S_SHDN,
    S_RESP,
    S_DMP_RD,
    S_DMP_OUT
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [KEY_W-1:0]        number;
    logic signed [QTY_W-1:0] qty;
    logic                    last;
  } resp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/skt_req_if.sv -----
// Request channel of the sorted keyed part table.
// Depends on skt_pkg.
`default_nettype none
interface skt_req_if;
  import skt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [TYPE_W-1:0]       req_type;
  logic [KEY_W-1:0]        part_number;
  logic signed [QTY_W-1:0] quantity;

  modport source (output valid, req_type, part_number, quantity, input ready);
  modport sink (input valid, req_type, part_number, quantity, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/skt_rsp_if.sv -----
// Result channel of the sorted keyed part table.
// Depends on skt_pkg.
`default_nettype none
interface skt_rsp_if;
  import skt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [KEY_W-1:0]        found_number;
  logic signed [QTY_W-1:0] on_hand;
  logic                    last;

  modport source (output valid, status, found_number, on_hand, last, input ready);
  modport sink (input valid, status, found_number, on_hand, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/skt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/skt_alu.sv -----
// Shared key comparator and saturating quantity adder.
// Depends on skt_pkg.
`default_nettype none
module skt_alu (
  input  wire logic [skt_pkg::KEY_W-1:0]        a_key,
  input  wire logic [skt_pkg::KEY_W-1:0]        b_key,
  input  wire logic signed [skt_pkg::QTY_W-1:0] a_qty,
  input  wire logic signed [skt_pkg::QTY_W-1:0] b_qty,
  output logic                                  lt,
  output logic                                  eq,
  output logic signed [skt_pkg::QTY_W-1:0]      sum
);
  import skt_pkg::*;

  logic signed [QTY_W:0] wide;

  assign lt   = a_key < b_key;
  assign eq   = a_key == b_key;
  assign wide = {a_qty[QTY_W-1], a_qty} + {b_qty[QTY_W-1], b_qty};

  always_comb begin
    if (wide[QTY_W] != wide[QTY_W-1]) begin
      sum = wide[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
    end else begin
      sum = wide[QTY_W-1:0];
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/skt_seq.sv -----
// Request sequencer: seek, shift, update and dump over the entry RAM.
// Depends on skt_pkg and skt_alu.
`default_nettype none
module skt_seq #(
  parameter int CAPACITY = skt_pkg::DEF_CAPACITY,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [skt_pkg::TYPE_W-1:0]        in_type,
  input  wire logic [skt_pkg::KEY_W-1:0]         in_key,
  input  wire logic signed [skt_pkg::QTY_W-1:0]  in_qty,
  input  wire logic                              out_free,
  output logic                                   out_load,
  output skt_pkg::resp_t                         out_resp,
  output logic                                   re,
  output logic [AW-1:0]                          raddr,
  input  wire logic [skt_pkg::KEY_W-1:0]         rd_key,
  input  wire logic signed [skt_pkg::QTY_W-1:0]  rd_qty,
  output logic                                   we,
  output logic [AW-1:0]                          waddr,
  output logic [skt_pkg::KEY_W-1:0]              wkey,
  output logic signed [skt_pkg::QTY_W-1:0]       wqty
);
  import skt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE  = CW'(1);

  state_t                  state, state_next;
  logic [TYPE_W-1:0]       rtype, rtype_next;
  logic [KEY_W-1:0]        rkey, rkey_next;
  logic signed [QTY_W-1:0] rqty, rqty_next;
  logic [CW-1:0]           count, count_next;
  logic [CW-1:0]           pos, pos_next;
  logic [CW-1:0]           scan, scan_next;
  logic                    primed, primed_next;
  logic [CW-1:0]           dst, dst_next;
  logic                    pend, pend_next;
  logic [AW-1:0]           pend_dst, pend_dst_next;
  resp_t                   res, res_next;

  logic                    cmp_lt, cmp_eq;
  logic signed [QTY_W-1:0] sat_sum;
  logic [CW-1:0]           pos_inc, dst_inc, dst_dec;

  skt_alu u_alu (
    .a_key (rd_key),
    .b_key (rkey),
    .a_qty (rd_qty),
    .b_qty (rqty),
    .lt    (cmp_lt),
    .eq    (cmp_eq),
    .sum   (sat_sum)
  );

  assign pos_inc = pos + ONE;
  assign dst_inc = dst + ONE;
  assign dst_dec = dst - ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rtype    <= rtype_next;
    rkey     <= rkey_next;
    rqty     <= rqty_next;
    pos      <= pos_next;
    scan     <= scan_next;
    primed   <= primed_next;
    dst      <= dst_next;
    pend_dst <= pend_dst_next;
    res      <= res_next;
  end

  always_comb begin
    state_next    = state;
    rtype_next    = rtype;
    rkey_next     = rkey;
    rqty_next     = rqty;
    count_next    = count;
    pos_next      = pos;
    scan_next     = scan;
    primed_next   = primed;
    dst_next      = dst;
    pend_next     = pend;
    pend_dst_next = pend_dst;
    res_next      = res;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    out_resp      = res;
    re            = 1'b0;
    raddr         = '0;
    we            = 1'b0;
    waddr         = '0;
    wkey          = rkey;
    wqty          = rqty;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rtype_next = in_type;
          rkey_next  = in_key;
          rqty_next  = in_qty;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        pos_next    = '0;
        scan_next   = '0;
        primed_next = 1'b0;
        case (rtype)
          REQ_INSERT: begin
            if (count == FULL) begin
              res_next   = '{status: ST_FULL, number: rkey, qty: '0, last: 1'b1};
              state_next = S_RESP;
            end else begin
              state_next = S_SEEK;
            end
          end
          REQ_SEARCH, REQ_UPDATE, REQ_ERASE: begin
            state_next = S_SEEK;
          end
          REQ_DUMP: begin
            if (count == '0) begin
              res_next   = '{status: ST_EMPTY, number: '0, qty: '0, last: 1'b1};
              state_next = S_RESP;
            end else begin
              state_next = S_DMP_RD;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_SEEK: begin
        re    = 1'b1;
        raddr = scan[AW-1:0];
        if (pos != count && !primed) begin
          primed_next = 1'b1;
          scan_next   = scan + ONE;
        end else if (pos != count && cmp_lt) begin
          pos_next  = pos_inc;
          scan_next = scan + ONE;
        end else begin
          if (rtype == REQ_INSERT) begin
            if (pos != count && cmp_eq) begin
              res_next   = '{status: ST_DUP, number: rkey, qty: rd_qty, last: 1'b1};
              state_next = S_RESP;
            end else begin
              dst_next   = count;
              pend_next  = 1'b0;
              state_next = S_SHUP;
            end
          end else if (pos == count || !cmp_eq) begin
            res_next   = '{status: ST_NFOUND, number: rkey, qty: '0, last: 1'b1};
            state_next = S_RESP;
          end else if (rtype == REQ_UPDATE) begin
            we         = 1'b1;
            waddr      = pos[AW-1:0];
            wqty       = sat_sum;
            res_next   = '{status: ST_OK, number: rkey, qty: sat_sum, last: 1'b1};
            state_next = S_RESP;
          end else if (rtype == REQ_ERASE) begin
            res_next   = '{status: ST_OK, number: rkey, qty: rd_qty, last: 1'b1};
            dst_next   = pos;
            pend_next  = 1'b0;
            state_next = S_SHDN;
          end else begin
            res_next   = '{status: ST_OK, number: rkey, qty: rd_qty, last: 1'b1};
            state_next = S_RESP;
          end
        end
      end

      S_SHUP: begin
        if (pend) begin
          we    = 1'b1;
          waddr = pend_dst;
          wkey  = rd_key;
          wqty  = rd_qty;
        end
        if (dst > pos) begin
          re            = 1'b1;
          raddr         = dst_dec[AW-1:0];
          pend_next     = 1'b1;
          pend_dst_next = dst[AW-1:0];
          dst_next      = dst_dec;
        end else begin
          pend_next  = 1'b0;
          state_next = S_INS_WR;
        end
      end

      S_INS_WR: begin
        we         = 1'b1;
        waddr      = pos[AW-1:0];
        count_next = count + ONE;
        res_next   = '{status: ST_OK, number: rkey, qty: rqty, last: 1'b1};
        state_next = S_RESP;
      end

      S_SHDN: begin
        if (pend) begin
          we    = 1'b1;
          waddr = pend_dst;
          wkey  = rd_key;
          wqty  = rd_qty;
        end
        if (dst_inc < count) begin
          re            = 1'b1;
          raddr         = dst_inc[AW-1:0];
          pend_next     = 1'b1;
          pend_dst_next = dst[AW-1:0];
          dst_next      = dst_inc;
        end else begin
          pend_next  = 1'b0;
          count_next = count - ONE;
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_DMP_RD: begin
        re         = 1'b1;
        raddr      = pos[AW-1:0];
        state_next = S_DMP_OUT;
      end

      S_DMP_OUT: begin
        out_resp = '{status: ST_OK, number: rd_key, qty: rd_qty, last: pos_inc == count};
        if (out_free) begin
          out_load = 1'b1;
          pos_next = pos_inc;
          if (pos_inc == count) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_DMP_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/sorted_keyed_part_table.sv -----
// Channel   Dir  Payload
// req       in   req_type, part_number, quantity
// rsp       out  status, found_number, on_hand, last
//
// A request is decoded, then the seek walks the entries in order; an insert then shifts
// the entries above its place up and writes the new entry, an erase shifts the entries
// above it down. A full insert or an empty dump answers without a seek; a dump reads and
// sends each entry in turn. The single-read, single-write entry RAM moves one entry at a time.
// Reset clears the count and the sequencer at once; there is no clearing pass.
// A stalled result holds in the output register; the next request is taken meanwhile.
//
// Top level of the sorted keyed part table.
// Depends on skt_pkg, skt_req_if, skt_rsp_if, skt_ram and skt_seq.
`default_nettype none
module sorted_keyed_part_table #(
  parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
  input wire logic  clk,
  input wire logic  rst,
  skt_req_if.sink   req,
  skt_rsp_if.source rsp
);
  import skt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DW = KEY_W + QTY_W;

  logic                    re, we, out_load, out_free;
  logic [AW-1:0]           raddr, waddr;
  logic [DW-1:0]           rdata;
  logic [KEY_W-1:0]        wkey;
  logic signed [QTY_W-1:0] wqty;
  resp_t                   out_resp;
  resp_t                   result;
  logic                    result_valid;

  assign out_free = !result_valid || rsp.ready;

  skt_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({wkey, wqty}),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  skt_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_type  (req.req_type),
    .in_key   (req.part_number),
    .in_qty   (req.quantity),
    .out_free (out_free),
    .out_load (out_load),
    .out_resp (out_resp),
    .re       (re),
    .raddr    (raddr),
    .rd_key   (rdata[DW-1:QTY_W]),
    .rd_qty   (rdata[QTY_W-1:0]),
    .we       (we),
    .waddr    (waddr),
    .wkey     (wkey),
    .wqty     (wqty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (rsp.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= out_resp;
    end
  end

  assign rsp.valid        = result_valid;
  assign rsp.status       = result.status;
  assign rsp.found_number = result.number;
  assign rsp.on_hand      = result.qty;
  assign rsp.last         = result.last;
endmodule
`default_nettype wire

// ----- hw/rtl/skt_check.sv -----
// Port-level checker for the sorted keyed part table, bound to the top level.
// Depends on skt_pkg and sorted_keyed_part_table_macros.svh.
`default_nettype none
`include "sorted_keyed_part_table_macros.svh"
module skt_check (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              req_valid,
  input wire logic                              req_ready,
  input wire logic                              rsp_valid,
  input wire logic                              rsp_ready,
  input wire logic [skt_pkg::STAT_W-1:0]        rsp_status,
  input wire logic [skt_pkg::KEY_W-1:0]         rsp_found_number,
  input wire logic signed [skt_pkg::QTY_W-1:0]  rsp_on_hand,
  input wire logic                              rsp_last
);
  import skt_pkg::*;

  `SKT_ASSERT_IMP(a_reset_quiet, $fell(rst), !rsp_valid, "result valid straight after reset")
  `SKT_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")
  `SKT_ASSERT_IMP(a_error_last, rsp_valid && (rsp_status == ST_NFOUND || rsp_status == ST_DUP || rsp_status == ST_FULL || rsp_status == ST_EMPTY), rsp_last, "error result not marked last")
  `SKT_ASSERT_IMP(a_empty_zero, rsp_valid && rsp_status == ST_EMPTY, rsp_found_number == '0 && rsp_on_hand == '0, "empty result carries data")
  `SKT_ASSERT_NXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_on_hand), "stalled result dropped or changed")
endmodule

bind sorted_keyed_part_table skt_check u_check (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_found_number (rsp.found_number),
  .rsp_on_hand      (rsp.on_hand),
  .rsp_last         (rsp.last)
);
`default_nettype wire
